// ===== hdl/lav_pkg.sv =====
// shared constants for the look-at view matrix block
package lav_pkg;

  // default number of fraction bits in the fixed-point format
  localparam int FRAC_BITS_DEF = 16;

  // port widths fixed by the interface
  localparam int IN_W  = 32;
  localparam int ROW_W = 18;
  localparam int OFF_W = 32;

  // row codes, in the order the rows leave the block
  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;

endpackage

// ===== hdl/lav_norm.sv =====
// pipelined 3-vector normaliser: shift, sum of squares, square root, three dividers
module lav_norm #(
  parameter int FRAC   = lav_pkg::FRAC_BITS_DEF,
  parameter int W      = 33,
  parameter int SIDE_W = 1,
  localparam int FW    = FRAC + 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [2:0][W-1:0]       vec_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic [2:0][FW-1:0]      vec_o,
  output logic                    nz_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int M_W      = 30;
  localparam int SQ_STEPS = 31;
  localparam int S_W      = 2 * SQ_STEPS;
  localparam int EW       = (W > M_W) ? W : M_W;
  localparam int LZW      = $clog2(EW);
  localparam int QB       = FRAC + 1;
  localparam int RW       = FRAC + 33;
  localparam int DL       = 37 + QB;
  localparam int MTW      = SIDE_W + 4;

  logic [2:0][W-1:0]               mag_in;
  logic [2:0]                      neg_in;
  logic                            nz_in;

  logic [DL:0]                     vl_q;
  logic [DL:0][MTW-1:0]            mt_q;

  logic [2:0][EW-1:0]              a_mag_q;
  logic [EW-1:0]                   b_or;
  logic [LZW-1:0]                  lz_d;
  logic [2:0][EW-1:0]              b_mag_q;
  logic [LZW-1:0]                  b_lz_q;
  logic [2:0][EW-1:0]              c_sh;
  logic [2:0][M_W-1:0]             c_m_q;
  logic [2:0][2*M_W-1:0]           d_sq_q;
  logic [2:0][M_W-1:0]             d_m_q;

  logic [SQ_STEPS:0][S_W-1:0]      sq_s_q;
  logic [SQ_STEPS:0][S_W-1:0]      sq_r_q;
  logic [SQ_STEPS:0][2:0][M_W-1:0] sq_m_q;
  logic [SQ_STEPS-1:0][S_W-1:0]    sq_s_d;
  logic [SQ_STEPS-1:0][S_W-1:0]    sq_r_d;

  logic [30:0]                     len;
  logic [QB:0][31:0]               dv_den_q;
  logic [QB:0][2:0][RW-1:0]        dv_rem_q;
  logic [QB:0][2:0][QB-1:0]        dv_quo_q;
  logic [QB-1:0][2:0][RW-1:0]      dv_rem_d;
  logic [QB-1:0][2:0][QB-1:0]      dv_quo_d;

  logic [2:0][FW-1:0]              vec_q;
  logic [2:0]                      out_neg;
  logic                            out_nz;

  // magnitudes and signs of the incoming components
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = vec_i[i][W-1];
      mag_in[i] = neg_in[i] ? (~vec_i[i] + W'(1)) : vec_i[i];
    end
    nz_in = (vec_i != '0);
  end

  // valid bits travel down the whole pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q <= '0;
    end else begin
      vl_q <= {vl_q[DL-1:0], valid_i};
    end
  end

  // side data, signs and zero flag delayed alongside
  always_ff @(posedge clk_i) begin
    mt_q <= {mt_q[DL-1:0], {side_i, neg_in, nz_in}};
  end

  // leading-zero count of the largest magnitude
  always_comb begin
    b_or = a_mag_q[0] | a_mag_q[1] | a_mag_q[2];
    lz_d = '0;
    for (int i = 0; i < EW; i++) begin
      if (b_or[i]) begin
        lz_d = LZW'(EW - 1 - i);
      end
    end
  end

  // left-justify so the top bit of the largest magnitude lands on bit 29
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_sh[i] = b_mag_q[i] << b_lz_q;
    end
  end

  // front stages: magnitude, shift count, scaled magnitude, squares, sum
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      a_mag_q[i]   <= EW'(mag_in[i]);
      b_mag_q[i]   <= a_mag_q[i];
      c_m_q[i]     <= c_sh[i][EW-1 -: M_W];
      d_sq_q[i]    <= c_m_q[i] * c_m_q[i];
      d_m_q[i]     <= c_m_q[i];
    end
    b_lz_q    <= lz_d;
    sq_s_q[0] <= S_W'(d_sq_q[0]) + S_W'(d_sq_q[1]) + S_W'(d_sq_q[2]);
    sq_r_q[0] <= '0;
    sq_m_q[0] <= d_m_q;
  end

  // square root, one result bit per stage
  always_comb begin
    logic [S_W-1:0] bitv;
    logic [S_W:0]   trial;
    for (int i = 0; i < SQ_STEPS; i++) begin
      bitv  = S_W'(1) << (2 * (SQ_STEPS - 1 - i));
      trial = {1'b0, sq_r_q[i]} + {1'b0, bitv};
      if ({1'b0, sq_s_q[i]} >= trial) begin
        sq_s_d[i] = sq_s_q[i] - trial[S_W-1:0];
        sq_r_d[i] = (sq_r_q[i] >> 1) + bitv;
      end else begin
        sq_s_d[i] = sq_s_q[i];
        sq_r_d[i] = sq_r_q[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SQ_STEPS; i++) begin
      sq_s_q[i+1] <= sq_s_d[i];
      sq_r_q[i+1] <= sq_r_d[i];
      sq_m_q[i+1] <= sq_m_q[i];
    end
  end

  assign len = sq_r_q[SQ_STEPS][30:0];

  // restoring division with rounding, one quotient bit per stage per lane
  always_comb begin
    logic [RW-1:0] dsh;
    for (int j = 0; j < QB; j++) begin
      dsh = RW'(dv_den_q[j]) << (QB - 1 - j);
      for (int l = 0; l < 3; l++) begin
        if (dv_rem_q[j][l] >= dsh) begin
          dv_rem_d[j][l] = dv_rem_q[j][l] - dsh;
          dv_quo_d[j][l] = dv_quo_q[j][l] | (QB'(1) << (QB - 1 - j));
        end else begin
          dv_rem_d[j][l] = dv_rem_q[j][l];
          dv_quo_d[j][l] = dv_quo_q[j][l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_den_q[0] <= {len, 1'b0};
    for (int l = 0; l < 3; l++) begin
      dv_rem_q[0][l] <= (RW'(sq_m_q[SQ_STEPS][l]) << QB) + RW'(len);
      dv_quo_q[0][l] <= '0;
    end
    for (int j = 0; j < QB; j++) begin
      dv_den_q[j+1] <= dv_den_q[j];
      dv_rem_q[j+1] <= dv_rem_d[j];
      dv_quo_q[j+1] <= dv_quo_d[j];
    end
  end

  // sign restore, zero vector gives zeros
  assign out_neg = mt_q[DL-1][3:1];
  assign out_nz  = mt_q[DL-1][0];

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      if (!out_nz) begin
        vec_q[l] <= '0;
      end else if (out_neg[l]) begin
        vec_q[l] <= FW'(0) - FW'(dv_quo_q[QB][l]);
      end else begin
        vec_q[l] <= FW'(dv_quo_q[QB][l]);
      end
    end
  end

  assign valid_o = vl_q[DL];
  assign vec_o   = vec_q;
  assign nz_o    = mt_q[DL][0];
  assign side_o  = mt_q[DL][MTW-1:4];

endmodule

// ===== hdl/look_at_view_matrix.sv =====
// top level of the look-at view matrix block
//
// Usage: drive camera, target and up hint (signed, FRAC_BITS fraction bits)
// with start_i high; the transaction is taken on a rising edge where busy_o
// is low. busy_o then stays high while the busy counter runs down, so no
// transaction is taken before the single result channel is free for it.
// Each transaction gives three result rows on consecutive cycles, each marked
// by valid_o for one cycle: right (row 0), up (row 1), forward (row 2, with
// last_row_o high). The receiver cannot stall; results are simply presented.
// The first strobe follows the accepting edge through three normalisers in
// series, each a 31-stage square root followed by a FRAC_BITS+1 stage divider.
// The datapath is fully pipelined, so transactions overlap inside it.
// Reset clears all valid bits and the busy counter; nothing is emitted
// until a new transaction arrives.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [lav_pkg::IN_W-1:0]    cam_x_i,
  input  logic [lav_pkg::IN_W-1:0]    cam_y_i,
  input  logic [lav_pkg::IN_W-1:0]    cam_z_i,
  input  logic [lav_pkg::IN_W-1:0]    target_x_i,
  input  logic [lav_pkg::IN_W-1:0]    target_y_i,
  input  logic [lav_pkg::IN_W-1:0]    target_z_i,
  input  logic [lav_pkg::IN_W-1:0]    up_x_i,
  input  logic [lav_pkg::IN_W-1:0]    up_y_i,
  input  logic [lav_pkg::IN_W-1:0]    up_z_i,
  output logic                        valid_o,
  output logic [lav_pkg::ROW_W-1:0]   row_x_o,
  output logic [lav_pkg::ROW_W-1:0]   row_y_o,
  output logic [lav_pkg::ROW_W-1:0]   row_z_o,
  output logic [lav_pkg::OFF_W-1:0]   row_offset_o,
  output logic [1:0]                  row_number_o,
  output logic                        last_row_o,
  output logic                        degenerate_o
);

  localparam int IW    = lav_pkg::IN_W;
  localparam int RWD   = lav_pkg::ROW_W;
  localparam int OFW   = lav_pkg::OFF_W;
  localparam int FW    = FRAC_BITS + 2;
  localparam int PW    = IW + FW;
  localparam int CW    = PW + 1;
  localparam int UW    = 2 * FW + 1;
  localparam int OW    = PW + 3;
  localparam int SF_W  = 6 * IW;
  localparam int SR_W  = 2 + 3 * FW + 3 * IW;
  localparam int SU_W  = 1 + 6 * FW + 3 * IW;

  localparam logic [63:0] THR   = ((64'd1 << (2 * FRAC_BITS)) + 64'd500) / 64'd1000;
  localparam int          SH    = (2 * FRAC_BITS > 32) ? (2 * FRAC_BITS - 32) : 0;
  localparam logic [63:0] THR_S = THR >> SH;
  localparam int          TW    = $clog2(THR_S + 64'd1);

  localparam logic [FW-1:0]        ONE_FW = FW'(1) << FRAC_BITS;
  localparam logic signed [OW-1:0] HALF   = OW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [OW-1:0] SAT_HI = OW'(2147483647);
  localparam logic signed [OW-1:0] SAT_LO = -SAT_HI - OW'(1);

  // signed products of the datapath
  function automatic logic [PW-1:0] mul_cf(input logic [IW-1:0] a, input logic [FW-1:0] b);
    logic signed [PW-1:0] r;
    r = $signed(a) * $signed(b);
    return r;
  endfunction

  function automatic logic [2*FW-1:0] mul_ff(input logic [FW-1:0] a, input logic [FW-1:0] b);
    logic signed [2*FW-1:0] r;
    r = $signed(a) * $signed(b);
    return r;
  endfunction

  // axis component to port width, as two's complement
  function automatic logic [RWD-1:0] to_row(input logic [FW-1:0] v);
    logic signed [63:0] w;
    w = $signed(v);
    return w[RWD-1:0];
  endfunction

  logic                         accept;
  logic [1:0]                   busy_cnt_q;
  logic [2:0][IW-1:0]           cam_in, tgt_in, up_in;

  logic                         s1_vld_q;
  logic [2:0][IW:0]             s1_d_q;
  logic [2:0][IW-1:0]           s1_cam_q, s1_up_q;

  logic                         nf_vld, nf_nz;
  logic [2:0][FW-1:0]           nf_vec;
  logic [SF_W-1:0]              nf_side;

  logic                         s2_vld_q, s2_degen_q;
  logic [2:0][FW-1:0]           s2_fwd_q;
  logic [2:0][IW-1:0]           s2_cam_q, s2_up_q;

  logic                         s3_vld_q, s3_degen_q;
  logic [5:0][PW-1:0]           s3_p_q;
  logic [2:0][FW-1:0]           s3_fwd_q;
  logic [2:0][IW-1:0]           s3_cam_q;

  logic                         s4_vld_q, s4_degen_q;
  logic [2:0][CW-1:0]           s4_rc_q;
  logic [2:0][FW-1:0]           s4_fwd_q;
  logic [2:0][IW-1:0]           s4_cam_q;

  logic [2:0][CW-1:0]           rc_mag;
  logic                         big_d;
  logic                         s5_vld_q, s5_degen_q, s5_big_q;
  logic [2:0][TW-1:0]           s5_tr_q;
  logic [2:0][CW-1:0]           s5_rc_q;
  logic [2:0][FW-1:0]           s5_fwd_q;
  logic [2:0][IW-1:0]           s5_cam_q;

  logic                         s6_vld_q, s6_degen_q, s6_big_q;
  logic [2:0][2*TW-1:0]         s6_sq_q;
  logic [2:0][CW-1:0]           s6_rc_q;
  logic [2:0][FW-1:0]           s6_fwd_q;
  logic [2:0][IW-1:0]           s6_cam_q;

  logic [2*TW+1:0]              tsum;
  logic                         s7_vld_q, s7_degen_q, s7_short_q;
  logic [2:0][CW-1:0]           s7_rc_q;
  logic [2:0][FW-1:0]           s7_fwd_q;
  logic [2:0][IW-1:0]           s7_cam_q;

  logic                         nr_vld, nr_nz;
  logic [2:0][FW-1:0]           nr_vec;
  logic [SR_W-1:0]              nr_side;

  logic                         s8_vld_q, s8_degen_q;
  logic [2:0][FW-1:0]           s8_right_q, s8_fwd_q;
  logic [2:0][IW-1:0]           s8_cam_q;

  logic                         s9_vld_q, s9_degen_q;
  logic [5:0][2*FW-1:0]         s9_p_q;
  logic [2:0][FW-1:0]           s9_right_q, s9_fwd_q;
  logic [2:0][IW-1:0]           s9_cam_q;

  logic                         s10_vld_q, s10_degen_q;
  logic [2:0][UW-1:0]           s10_uc_q;
  logic [2:0][FW-1:0]           s10_right_q, s10_fwd_q;
  logic [2:0][IW-1:0]           s10_cam_q;

  logic                         nu_vld, nu_nz;
  logic [2:0][FW-1:0]           nu_vec;
  logic [SU_W-1:0]              nu_side;
  logic [2:0][2:0][FW-1:0]      nu_ax;
  logic [2:0][IW-1:0]           nu_cam;

  logic                         s11_vld_q, s11_degen_q;
  logic [2:0][2:0][PW-1:0]      s11_p_q;
  logic [2:0][2:0][FW-1:0]      s11_ax_q;

  logic                         s12_vld_q, s12_degen_q;
  logic [2:0][OW-1:0]           v_d;
  logic [2:0][OW-1:0]           s12_v_q;
  logic [2:0][2:0][FW-1:0]      s12_ax_q;

  logic [2:0][OFW-1:0]          off_d;
  logic                         s13_vld_q, s13_degen_q;
  logic [2:0][2:0][RWD-1:0]     s13_ax_q;
  logic [2:0][OFW-1:0]          s13_off_q;

  logic                         out_vld_q, run_q;
  logic [1:0]                   nxt_q;
  logic [1:0]                   sel;
  logic [RWD-1:0]               out_x_q, out_y_q, out_z_q;
  logic [OFW-1:0]               out_off_q;
  logic [1:0]                   out_num_q;
  logic                         out_deg_q;

  // input transaction handshake, refused while busy
  assign accept = start_i && !busy_o;
  assign busy_o = (busy_cnt_q != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_cnt_q <= 2'd0;
    end else if (accept) begin
      busy_cnt_q <= 2'd2;
    end else if (busy_cnt_q != 2'd0) begin
      busy_cnt_q <= busy_cnt_q - 2'd1;
    end
  end

  assign cam_in = {cam_z_i, cam_y_i, cam_x_i};
  assign tgt_in = {target_z_i, target_y_i, target_x_i};
  assign up_in  = {up_z_i, up_y_i, up_x_i};

  // valid bits of the top-level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      s13_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept;
      s2_vld_q  <= nf_vld;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= nr_vld;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= nu_vld;
      s12_vld_q <= s11_vld_q;
      s13_vld_q <= s12_vld_q;
    end
  end

  // camera minus target
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_d_q[i] <= {cam_in[i][IW-1], cam_in[i]} - {tgt_in[i][IW-1], tgt_in[i]};
    end
    s1_cam_q <= cam_in;
    s1_up_q  <= up_in;
  end

  // forward axis
  lav_norm #(
    .FRAC   (FRAC_BITS),
    .W      (IW + 1),
    .SIDE_W (SF_W)
  ) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_vld_q),
    .vec_i   (s1_d_q),
    .side_i  ({s1_cam_q, s1_up_q}),
    .valid_o (nf_vld),
    .vec_o   (nf_vec),
    .nz_o    (nf_nz),
    .side_o  (nf_side)
  );

  // fallback forward, then cross(up, forward)
  always_ff @(posedge clk_i) begin
    if (nf_nz) begin
      s2_fwd_q <= nf_vec;
    end else begin
      s2_fwd_q <= {ONE_FW, FW'(0), FW'(0)};
    end
    s2_degen_q <= !nf_nz;
    s2_cam_q   <= nf_side[SF_W-1:3*IW];
    s2_up_q    <= nf_side[3*IW-1:0];

    s3_p_q[0]  <= mul_cf(s2_up_q[1], s2_fwd_q[2]);
    s3_p_q[1]  <= mul_cf(s2_up_q[2], s2_fwd_q[1]);
    s3_p_q[2]  <= mul_cf(s2_up_q[2], s2_fwd_q[0]);
    s3_p_q[3]  <= mul_cf(s2_up_q[0], s2_fwd_q[2]);
    s3_p_q[4]  <= mul_cf(s2_up_q[0], s2_fwd_q[1]);
    s3_p_q[5]  <= mul_cf(s2_up_q[1], s2_fwd_q[0]);
    s3_fwd_q   <= s2_fwd_q;
    s3_cam_q   <= s2_cam_q;
    s3_degen_q <= s2_degen_q;

    for (int i = 0; i < 3; i++) begin
      s4_rc_q[i] <= {s3_p_q[2*i][PW-1], s3_p_q[2*i]}
                  - {s3_p_q[2*i+1][PW-1], s3_p_q[2*i+1]};
    end
    s4_fwd_q   <= s3_fwd_q;
    s4_cam_q   <= s3_cam_q;
    s4_degen_q <= s3_degen_q;
  end

  // near-parallel test on the raw cross product
  always_comb begin
    big_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rc_mag[i] = s4_rc_q[i][CW-1] ? (~s4_rc_q[i] + CW'(1)) : s4_rc_q[i];
      if (64'(rc_mag[i]) >= THR) begin
        big_d = 1'b1;
      end
    end
  end

  assign tsum = (2*TW+2)'(s6_sq_q[0]) + (2*TW+2)'(s6_sq_q[1]) + (2*TW+2)'(s6_sq_q[2]);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s5_tr_q[i] <= TW'(rc_mag[i] >> SH);
      s6_sq_q[i] <= s5_tr_q[i] * s5_tr_q[i];
    end
    s5_big_q   <= big_d;
    s5_rc_q    <= s4_rc_q;
    s5_fwd_q   <= s4_fwd_q;
    s5_cam_q   <= s4_cam_q;
    s5_degen_q <= s4_degen_q;

    s6_big_q   <= s5_big_q;
    s6_rc_q    <= s5_rc_q;
    s6_fwd_q   <= s5_fwd_q;
    s6_cam_q   <= s5_cam_q;
    s6_degen_q <= s5_degen_q;

    s7_short_q <= !s6_big_q && (64'(tsum) < THR_S * THR_S);
    s7_rc_q    <= s6_rc_q;
    s7_fwd_q   <= s6_fwd_q;
    s7_cam_q   <= s6_cam_q;
    s7_degen_q <= s6_degen_q;
  end

  // right axis
  lav_norm #(
    .FRAC   (FRAC_BITS),
    .W      (CW),
    .SIDE_W (SR_W)
  ) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s7_vld_q),
    .vec_i   (s7_rc_q),
    .side_i  ({s7_short_q, s7_degen_q, s7_fwd_q, s7_cam_q}),
    .valid_o (nr_vld),
    .vec_o   (nr_vec),
    .nz_o    (nr_nz),
    .side_o  (nr_side)
  );

  // fallback right, then cross(forward, right)
  always_ff @(posedge clk_i) begin
    if (nr_side[SR_W-1] || !nr_nz) begin
      s8_right_q <= {FW'(0), FW'(0), ONE_FW};
    end else begin
      s8_right_q <= nr_vec;
    end
    s8_degen_q <= nr_side[SR_W-2];
    s8_fwd_q   <= nr_side[3*IW+3*FW-1:3*IW];
    s8_cam_q   <= nr_side[3*IW-1:0];

    s9_p_q[0]  <= mul_ff(s8_fwd_q[1], s8_right_q[2]);
    s9_p_q[1]  <= mul_ff(s8_fwd_q[2], s8_right_q[1]);
    s9_p_q[2]  <= mul_ff(s8_fwd_q[2], s8_right_q[0]);
    s9_p_q[3]  <= mul_ff(s8_fwd_q[0], s8_right_q[2]);
    s9_p_q[4]  <= mul_ff(s8_fwd_q[0], s8_right_q[1]);
    s9_p_q[5]  <= mul_ff(s8_fwd_q[1], s8_right_q[0]);
    s9_right_q <= s8_right_q;
    s9_fwd_q   <= s8_fwd_q;
    s9_cam_q   <= s8_cam_q;
    s9_degen_q <= s8_degen_q;

    for (int i = 0; i < 3; i++) begin
      s10_uc_q[i] <= {s9_p_q[2*i][2*FW-1], s9_p_q[2*i]}
                   - {s9_p_q[2*i+1][2*FW-1], s9_p_q[2*i+1]};
    end
    s10_right_q <= s9_right_q;
    s10_fwd_q   <= s9_fwd_q;
    s10_cam_q   <= s9_cam_q;
    s10_degen_q <= s9_degen_q;
  end

  // up axis
  lav_norm #(
    .FRAC   (FRAC_BITS),
    .W      (UW),
    .SIDE_W (SU_W)
  ) u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s10_vld_q),
    .vec_i   (s10_uc_q),
    .side_i  ({s10_degen_q, s10_fwd_q, s10_right_q, s10_cam_q}),
    .valid_o (nu_vld),
    .vec_o   (nu_vec),
    .nz_o    (nu_nz),
    .side_o  (nu_side)
  );

  // axes in row order: right, up, forward
  assign nu_cam   = nu_side[3*IW-1:0];
  assign nu_ax[0] = nu_side[3*IW+3*FW-1:3*IW];
  assign nu_ax[1] = nu_nz ? nu_vec : '0;
  assign nu_ax[2] = nu_side[3*IW+6*FW-1:3*IW+3*FW];

  // offset: negate the dot product, round to nearest, saturate
  always_comb begin
    logic signed [OW-1:0] e0, e1, e2, r;
    for (int a = 0; a < 3; a++) begin
      e0 = $signed(s11_p_q[a][0]);
      e1 = $signed(s11_p_q[a][1]);
      e2 = $signed(s11_p_q[a][2]);
      v_d[a] = HALF - e0 - e1 - e2;
      r = $signed(s12_v_q[a]) >>> FRAC_BITS;
      if (r > SAT_HI) begin
        off_d[a] = SAT_HI[OFW-1:0];
      end else if (r < SAT_LO) begin
        off_d[a] = SAT_LO[OFW-1:0];
      end else begin
        off_d[a] = r[OFW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < 3; i++) begin
        s11_p_q[a][i] <= mul_cf(nu_cam[i], nu_ax[a][i]);
      end
    end
    s11_ax_q    <= nu_ax;
    s11_degen_q <= nu_side[SU_W-1];

    s12_v_q     <= v_d;
    s12_ax_q    <= s11_ax_q;
    s12_degen_q <= s11_degen_q;

    // held until the three rows have left
    if (s12_vld_q) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          s13_ax_q[a][i] <= to_row(s12_ax_q[a][i]);
        end
      end
      s13_off_q   <= off_d;
      s13_degen_q <= s12_degen_q;
    end
  end

  // row sequencer, one row per cycle
  assign sel = s13_vld_q ? lav_pkg::ROW_RIGHT : nxt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      run_q     <= 1'b0;
      nxt_q     <= lav_pkg::ROW_RIGHT;
    end else begin
      out_vld_q <= s13_vld_q || run_q;
      if (s13_vld_q) begin
        run_q <= 1'b1;
        nxt_q <= lav_pkg::ROW_UP;
      end else if (run_q) begin
        if (nxt_q == lav_pkg::ROW_FWD) begin
          run_q <= 1'b0;
          nxt_q <= lav_pkg::ROW_RIGHT;
        end else begin
          nxt_q <= lav_pkg::ROW_FWD;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    case (sel)
      lav_pkg::ROW_UP: begin
        out_x_q   <= s13_ax_q[1][0];
        out_y_q   <= s13_ax_q[1][1];
        out_z_q   <= s13_ax_q[1][2];
        out_off_q <= s13_off_q[1];
      end
      lav_pkg::ROW_FWD: begin
        out_x_q   <= s13_ax_q[2][0];
        out_y_q   <= s13_ax_q[2][1];
        out_z_q   <= s13_ax_q[2][2];
        out_off_q <= s13_off_q[2];
      end
      default: begin
        out_x_q   <= s13_ax_q[0][0];
        out_y_q   <= s13_ax_q[0][1];
        out_z_q   <= s13_ax_q[0][2];
        out_off_q <= s13_off_q[0];
      end
    endcase
    out_num_q <= sel;
    out_deg_q <= s13_degen_q;
  end

  assign valid_o      = out_vld_q;
  assign row_x_o      = out_x_q;
  assign row_y_o      = out_y_q;
  assign row_z_o      = out_z_q;
  assign row_offset_o = out_off_q;
  assign row_number_o = out_num_q;
  assign last_row_o   = (out_num_q == lav_pkg::ROW_FWD);
  assign degenerate_o = out_deg_q;

endmodule
